FILE: rtl/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// Shared types and constants for the hashed timer wheel.
// ----------------------------------------------------------------------------
package htw_pkg;

  localparam int WHEEL_SLOTS = 4096;
  localparam int SLOT_W      = $clog2(WHEEL_SLOTS);
  localparam int NUM_TIMERS  = 63;
  localparam int TIMER_W     = 6;
  localparam int TIMER_SLOTS = 2 ** TIMER_W;
  localparam int LINK_W      = TIMER_W + 1;
  localparam int ROT_W       = 24 - SLOT_W;

  localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(1) << TIMER_W;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } htw_op_t;

  typedef enum logic [1:0] {
    RES_DONE     = 2'd0,
    RES_EXPIRED  = 2'd1,
    RES_WALK_END = 2'd2
  } htw_res_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UNL_EX,
    ST_APP_RD,
    ST_APP_EX,
    ST_APP_LINK,
    ST_TICK_RD,
    ST_TICK_HEAD,
    ST_WALK_RD,
    ST_WALK_EX,
    ST_DONE
  } htw_state_t;

endpackage

FILE: rtl/htw_ram.sv
// ----------------------------------------------------------------------------
// htw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/hashed_timer_wheel.sv
// ----------------------------------------------------------------------------
// hashed_timer_wheel
// Timer pool on a wheel of linked spokes, held in synchronous RAMs.
// ----------------------------------------------------------------------------
// After reset a clearing pass empties all 4096 spokes; busy is high.
// Tick: one result per expiry on the spoke, then a closing result.
// One request at a time; the next is accepted with the final result.
// Each RAM has one read and one write port.
// Results are strobed on done for one cycle; the receiver cannot stall.
module hashed_timer_wheel (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [5:0]  timer_number,
  input  logic [23:0] duration_ticks,
  output logic        done,
  output logic [1:0]  result_kind,
  output logic [5:0]  expired_number,
  output logic [6:0]  running_count,
  output logic [31:0] expiration_total,
  output logic        last
);

  htw_pkg::htw_state_t state, state_next;

  logic [htw_pkg::SLOT_W-1:0]      clr_cnt;
  logic [htw_pkg::SLOT_W-1:0]      pos;
  logic [1:0]                      op_kind;
  logic [htw_pkg::TIMER_W-1:0]     op_timer;
  logic [23:0]                     op_dur;
  logic [htw_pkg::LINK_W-1:0]      cur;
  logic [htw_pkg::LINK_W-1:0]      tl;
  logic [htw_pkg::TIMER_SLOTS-1:0] running;
  logic [6:0]                      total;
  logic [31:0]                     expiry;

  logic                            accept;
  logic                            in_pool;
  logic [htw_pkg::SLOT_W-1:0]      s_app;
  logic                            unl;
  logic                            emit_exp;
  logic [htw_pkg::TIMER_W-1:0]     t_raddr;

  logic [htw_pkg::LINK_W-1:0]      head_rd, tail_rd, next_rd, prev_rd;
  logic [htw_pkg::ROT_W-1:0]       rot_rd;
  logic [htw_pkg::SLOT_W-1:0]      lspk_rd;

  logic                            head_we, tail_we, next_we, prev_we, rot_we, lspk_we;
  logic [htw_pkg::SLOT_W-1:0]      head_wa, tail_wa;
  logic [htw_pkg::LINK_W-1:0]      head_wd, tail_wd, next_wd, prev_wd;
  logic [htw_pkg::TIMER_W-1:0]     next_wa, prev_wa, rot_wa, lspk_wa;
  logic [htw_pkg::ROT_W-1:0]       rot_wd;
  logic [htw_pkg::SLOT_W-1:0]      lspk_wd;

  assign busy     = (state != htw_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign in_pool  = (timer_number < htw_pkg::TIMER_W'(htw_pkg::NUM_TIMERS));
  assign s_app    = pos + op_dur[htw_pkg::SLOT_W-1:0];
  assign unl      = (state == htw_pkg::ST_UNL_EX) ||
                    ((state == htw_pkg::ST_WALK_EX) && (rot_rd == '0));
  assign emit_exp = (state == htw_pkg::ST_WALK_EX) && (rot_rd == '0);
  assign t_raddr  = (state == htw_pkg::ST_WALK_RD) ? cur[htw_pkg::TIMER_W-1:0] : timer_number;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      htw_pkg::ST_CLEAR: begin
        if (clr_cnt == '1) state_next = htw_pkg::ST_IDLE;
      end
      htw_pkg::ST_IDLE: begin
        if (accept) begin
          if (kind == htw_pkg::OP_TICK) begin
            state_next = htw_pkg::ST_TICK_RD;
          end else if (in_pool && (kind == htw_pkg::OP_START || kind == htw_pkg::OP_STOP)
                       && running[timer_number]) begin
            state_next = htw_pkg::ST_UNL_EX;
          end else if (in_pool && kind == htw_pkg::OP_START) begin
            state_next = htw_pkg::ST_APP_RD;
          end else begin
            state_next = htw_pkg::ST_DONE;
          end
        end
      end
      htw_pkg::ST_UNL_EX:
        state_next = (op_kind == htw_pkg::OP_START) ? htw_pkg::ST_APP_RD : htw_pkg::ST_DONE;
      htw_pkg::ST_APP_RD:    state_next = htw_pkg::ST_APP_EX;
      htw_pkg::ST_APP_EX:
        state_next = tail_rd[htw_pkg::TIMER_W] ? htw_pkg::ST_DONE : htw_pkg::ST_APP_LINK;
      htw_pkg::ST_APP_LINK:  state_next = htw_pkg::ST_DONE;
      htw_pkg::ST_TICK_RD:   state_next = htw_pkg::ST_TICK_HEAD;
      htw_pkg::ST_TICK_HEAD:
        state_next = head_rd[htw_pkg::TIMER_W] ? htw_pkg::ST_DONE : htw_pkg::ST_WALK_RD;
      htw_pkg::ST_WALK_RD:   state_next = htw_pkg::ST_WALK_EX;
      htw_pkg::ST_WALK_EX:
        state_next = next_rd[htw_pkg::TIMER_W] ? htw_pkg::ST_DONE : htw_pkg::ST_WALK_RD;
      htw_pkg::ST_DONE:      state_next = htw_pkg::ST_IDLE;
      default:               state_next = htw_pkg::ST_IDLE;
    endcase
  end

  // RAM write ports
  always_comb begin
    head_we = 1'b0; head_wa = lspk_rd; head_wd = next_rd;
    tail_we = 1'b0; tail_wa = lspk_rd; tail_wd = prev_rd;
    next_we = 1'b0; next_wa = prev_rd[htw_pkg::TIMER_W-1:0]; next_wd = next_rd;
    prev_we = 1'b0; prev_wa = next_rd[htw_pkg::TIMER_W-1:0]; prev_wd = prev_rd;
    rot_we  = 1'b0; rot_wa  = cur[htw_pkg::TIMER_W-1:0];     rot_wd  = rot_rd - 1'b1;
    lspk_we = 1'b0; lspk_wa = op_timer;                      lspk_wd = s_app;
    case (state)
      htw_pkg::ST_CLEAR: begin
        head_we = 1'b1; head_wa = clr_cnt; head_wd = htw_pkg::LINK_NIL;
        tail_we = 1'b1; tail_wa = clr_cnt; tail_wd = htw_pkg::LINK_NIL;
      end
      htw_pkg::ST_UNL_EX, htw_pkg::ST_WALK_EX: begin
        if (unl) begin
          // splice out: predecessor or head gets next, successor or tail gets prev
          head_we = prev_rd[htw_pkg::TIMER_W];
          next_we = !prev_rd[htw_pkg::TIMER_W];
          tail_we = next_rd[htw_pkg::TIMER_W];
          prev_we = !next_rd[htw_pkg::TIMER_W];
        end else begin
          rot_we = 1'b1;
        end
      end
      htw_pkg::ST_APP_EX: begin
        head_we = tail_rd[htw_pkg::TIMER_W];
        head_wa = s_app; head_wd = {1'b0, op_timer};
        tail_we = 1'b1; tail_wa = s_app; tail_wd = {1'b0, op_timer};
        next_we = 1'b1; next_wa = op_timer; next_wd = htw_pkg::LINK_NIL;
        prev_we = 1'b1; prev_wa = op_timer; prev_wd = tail_rd;
        rot_we  = 1'b1; rot_wa  = op_timer; rot_wd  = op_dur[23:htw_pkg::SLOT_W];
        lspk_we = 1'b1;
      end
      htw_pkg::ST_APP_LINK: begin
        next_we = 1'b1; next_wa = tl[htw_pkg::TIMER_W-1:0]; next_wd = {1'b0, op_timer};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= htw_pkg::ST_CLEAR;
      clr_cnt <= '0;
      pos     <= '0;
      running <= '0;
      total   <= '0;
      expiry  <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == htw_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (accept) begin
        op_kind  <= kind;
        op_timer <= timer_number;
        op_dur   <= duration_ticks;
        if (kind == htw_pkg::OP_TICK) pos <= pos + 1'b1;
      end
      case (state)
        htw_pkg::ST_UNL_EX: begin
          running[op_timer] <= 1'b0;
          total             <= total - 1'b1;
        end
        htw_pkg::ST_APP_EX: begin
          running[op_timer] <= 1'b1;
          total             <= total + 1'b1;
          tl                <= tail_rd;
        end
        htw_pkg::ST_TICK_HEAD: cur <= head_rd;
        htw_pkg::ST_WALK_EX: begin
          cur <= next_rd;
          if (emit_exp) begin
            running[cur[htw_pkg::TIMER_W-1:0]] <= 1'b0;
            total            <= total - 1'b1;
            expiry           <= expiry + 1'b1;
            done             <= 1'b1;
            result_kind      <= htw_pkg::RES_EXPIRED;
            expired_number   <= cur[htw_pkg::TIMER_W-1:0];
            running_count    <= total - 1'b1;
            expiration_total <= expiry + 1'b1;
            last             <= 1'b0;
          end
        end
        htw_pkg::ST_DONE: begin
          done             <= 1'b1;
          result_kind      <= (op_kind == htw_pkg::OP_TICK) ? htw_pkg::RES_WALK_END
                                                            : htw_pkg::RES_DONE;
          expired_number   <= '0;
          running_count    <= total;
          expiration_total <= expiry;
          last             <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  htw_ram #(.WIDTH(htw_pkg::LINK_W), .DEPTH(htw_pkg::WHEEL_SLOTS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd), .raddr(pos), .rdata(head_rd));
  htw_ram #(.WIDTH(htw_pkg::LINK_W), .DEPTH(htw_pkg::WHEEL_SLOTS)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd), .raddr(s_app), .rdata(tail_rd));
  htw_ram #(.WIDTH(htw_pkg::LINK_W), .DEPTH(htw_pkg::TIMER_SLOTS)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd), .raddr(t_raddr),
    .rdata(next_rd));
  htw_ram #(.WIDTH(htw_pkg::LINK_W), .DEPTH(htw_pkg::TIMER_SLOTS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd), .raddr(t_raddr),
    .rdata(prev_rd));
  htw_ram #(.WIDTH(htw_pkg::ROT_W), .DEPTH(htw_pkg::TIMER_SLOTS)) u_rot (
    .clk(clk), .we(rot_we), .waddr(rot_wa), .wdata(rot_wd), .raddr(t_raddr), .rdata(rot_rd));
  htw_ram #(.WIDTH(htw_pkg::SLOT_W), .DEPTH(htw_pkg::TIMER_SLOTS)) u_lspk (
    .clk(clk), .we(lspk_we), .waddr(lspk_wa), .wdata(lspk_wd), .raddr(t_raddr),
    .rdata(lspk_rd));

endmodule

FILE: rtl/htw_checker.sv
// ----------------------------------------------------------------------------
// htw_checker
// Port-level checks on the hashed timer wheel, bound to the top level.
// ----------------------------------------------------------------------------
module htw_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  result_kind,
  input logic [5:0]  expired_number,
  input logic [6:0]  running_count,
  input logic        last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request accepted without going busy");

  a_nonlast_expiry: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> result_kind == htw_pkg::RES_EXPIRED)
    else $error("non-final result is not an expiry");

  a_number_zero: assert property (@(posedge clk) disable iff (rst)
    done && result_kind != htw_pkg::RES_EXPIRED |-> expired_number == '0)
    else $error("expired_number set on a closing result");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    done |-> running_count <= 7'(htw_pkg::NUM_TIMERS))
    else $error("running count exceeds pool");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    done && result_kind != htw_pkg::RES_EXPIRED |-> last)
    else $error("closing result without last");

endmodule

bind hashed_timer_wheel htw_checker u_htw_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .result_kind(result_kind), .expired_number(expired_number),
  .running_count(running_count), .last(last)
);
